@@ src/gwo_pkg.sv @@
`timescale 1ns / 1ps

package gwo_pkg;

    // Table geometry and sample format.
    localparam int TABLE_SIZE  = 512;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(TABLE_SIZE);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int QUARTER     = TABLE_SIZE / 4;
    localparam int QIDX_W      = ADDR_W - 1;

    // Phase accumulator: table position with a 16-bit fraction.
    localparam int PHASE_FRAC  = 16;
    localparam int PHASE_W     = ADDR_W + PHASE_FRAC;
    localparam int STEP_SHIFT  = 24;

    // Field widths fixed by the interface.
    localparam int OPCODE_W    = 2;
    localparam int FREQ_W      = 24;
    localparam int AMP_W       = 17;
    localparam int INC_W       = 32;
    localparam int HALF_W      = INC_W / 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Widths of the table build arithmetic.
    localparam int SQ_W        = 2 * ADDR_W + 1;
    localparam int DEN_W       = 3 * ADDR_W + 1;
    localparam int NUM_W       = DEN_W + SAMPLE_BITS;
    localparam int QUOT_W      = SAMPLE_BITS;
    localparam int FAC_W       = IDX_W + 2;
    localparam int SHRINK_W    = AMP_W + IDX_W;
    localparam int T_W         = PHASE_FRAC + SAMPLE_BITS;

    localparam logic [63:0] FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = SAMPLE_BITS'(FULL_SCALE - 64'd1);
    localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1 << 16);
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Request queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Opcodes of the input request.
    localparam logic [OPCODE_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_UPDATE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REBUILD = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_END         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_END_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_SHRINK_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INCREMENT_PER_HZ = 3'd4;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [FREQ_W-1:0]   frequency;
        logic [AMP_W-1:0]    amplitude;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          is_sample;
    } out_t;

    typedef struct packed {
        logic              waveform_mode;
        logic [IDX_W-1:0]  rise_end;
        logic [IDX_W-1:0]  fall_end_max;
        logic [IDX_W-1:0]  fall_shrink_max;
        logic [INC_W-1:0]  increment_per_hz;
    } cfg_t;

    // Command decided by the front for each accepted request.
    typedef enum logic [2:0] {
        CMD_NOP           = 3'd0,
        CMD_SAMPLE        = 3'd1,
        CMD_UPDATE        = 3'd2,
        CMD_REBUILD_PULSE = 3'd3,
        CMD_REBUILD_SINE  = 3'd4
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [FREQ_W-1:0] frequency;
        logic [AMP_W-1:0]  amplitude;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } queue_head_t;

    typedef struct packed {
        logic pop;
        logic hold;
    } back_stat_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

    typedef logic [SAMPLE_BITS-1:0] sine_rom_t [QUARTER+1];

    // One quarter period of sine magnitudes, built at elaboration with a
    // Q30 Taylor series up to the thirteenth power.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] step;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] mag;
        step = 64'd1 << (32 - ADDR_W);
        for (int k = 0; k <= QUARTER; k++) begin
            r    = 64'(k) * step;
            x    = (r * TWO_PI_Q30) >> 32;
            sum  = x;
            term = x;
            for (int n = 1; n <= 6; n++) begin
                term = (((term * x) >> 30) * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            mag = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
            if (mag > FULL_SCALE - 64'd1) begin
                mag = FULL_SCALE - 64'd1;
            end
            rom[k] = mag[SAMPLE_BITS-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ src/glottal_wavetable_oscillator.sv @@
// Sample request: split phase-step multiply, phase add, two table reads and interpolation give the result.
// Pulse rebuild: each rise and fall entry is computed by a divider run; zero entries are written directly.
// Amplitude update: fall entries rewritten by the divider; sine rebuild: from the ROM; no-op: result only.
// Requests are queued two deep, so a request is taken while a result waits to be read.
// Reset (aresetn, synchronous, active low) restores the registers, then clears the table with s_ready low.
`timescale 1ns / 1ps

module glottal_wavetable_oscillator import gwo_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    queue_head_t q_head;
    back_stat_t  bstat;

    // Configuration register file.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_WAVEFORM_MODE: begin
                    cfg_next.waveform_mode = cfg_wdata[0];
                end
                REG_RISE_END: begin
                    cfg_next.rise_end = cfg_wdata[IDX_W-1:0];
                end
                REG_FALL_END_MAX: begin
                    cfg_next.fall_end_max = cfg_wdata[IDX_W-1:0];
                end
                REG_FALL_SHRINK_MAX: begin
                    cfg_next.fall_shrink_max = cfg_wdata[IDX_W-1:0];
                end
                REG_INCREMENT_PER_HZ: begin
                    cfg_next.increment_per_hz = cfg_wdata[INC_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.waveform_mode    <= 1'b0;
            cfg_reg.rise_end         <= IDX_W'(205);
            cfg_reg.fall_end_max     <= IDX_W'(369);
            cfg_reg.fall_shrink_max  <= IDX_W'(82);
            cfg_reg.increment_per_hz <= INC_W'(49864474);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gwo_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .waveform_mode (cfg_reg.waveform_mode),
        .bstat         (bstat),
        .head          (q_head)
    );

    gwo_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .head    (q_head),
        .stat    (bstat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // The back only takes a request that the queue holds.
    assert property (@(posedge aclk) disable iff (!aresetn) bstat.pop |-> q_head.valid)
        else $error("request taken from an empty queue");

    // No request enters while the table is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn) bstat.hold |-> !s_ready)
        else $error("request accepted during table clearing");

    // Results that are not samples carry a zero sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_sample) |-> (m_data.sample == '0))
        else $error("non-sample result with a non-zero sample");

endmodule

@@ src/gwo_ram.sv @@
`timescale 1ns / 1ps

module gwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/gwo_front.sv @@
`timescale 1ns / 1ps

module gwo_front import gwo_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    input  logic        waveform_mode,
    input  back_stat_t  bstat,
    output queue_head_t head
);

    job_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    job_t              job_in;

    // Make a command; user must hold mode stable while work is pending; unchecked.
    always_comb begin
        job_in.frequency = s_data.frequency;
        job_in.amplitude = (s_data.amplitude > AMP_ONE) ? AMP_ONE : s_data.amplitude;
        case (s_data.opcode)
            OP_SAMPLE: begin
                job_in.cmd = CMD_SAMPLE;
            end
            OP_UPDATE: begin
                job_in.cmd = waveform_mode ? CMD_NOP : CMD_UPDATE;
            end
            OP_REBUILD: begin
                job_in.cmd = waveform_mode ? CMD_REBUILD_SINE : CMD_REBUILD_PULSE;
            end
            default: begin
                job_in.cmd = CMD_NOP;
            end
        endcase
    end

    // Accept while the queue has room and the table is not being cleared.
    assign s_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH)) && !bstat.hold;
    assign push    = s_valid && s_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (bstat.pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !bstat.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && bstat.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.job   = q_mem_reg[rd_ptr_reg];

endmodule

@@ src/gwo_div.sv @@
`timescale 1ns / 1ps

module gwo_div import gwo_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic              ge;

    // Restoring division, one quotient bit per cycle, most significant first.
    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(QUOT_W - 1);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.num;
            dsh_reg  <= NUM_W'({req.den, {(QUOT_W - 1){1'b0}}});
            quot_reg <= '0;
        end else if (run_reg) begin
            rem_reg  <= ge ? rem_reg - dsh_reg : rem_reg;
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ src/gwo_back.sv @@
`timescale 1ns / 1ps

module gwo_back import gwo_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  queue_head_t head,
    output back_stat_t  stat,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data
);

    typedef enum logic [20:0] {
        ST_CLEAR      = 21'd1 << 0,
        ST_IDLE       = 21'd1 << 1,
        ST_MUL_LO     = 21'd1 << 2,
        ST_MUL_HI     = 21'd1 << 3,
        ST_PHASE      = 21'd1 << 4,
        ST_RD_LO      = 21'd1 << 5,
        ST_RD_HI      = 21'd1 << 6,
        ST_INTERP     = 21'd1 << 7,
        ST_SUM        = 21'd1 << 8,
        ST_UPD_MUL    = 21'd1 << 9,
        ST_UPD_END    = 21'd1 << 10,
        ST_RISE_SQ    = 21'd1 << 11,
        ST_RISE_CUBE  = 21'd1 << 12,
        ST_FALL_SQ    = 21'd1 << 13,
        ST_ENT_SQ     = 21'd1 << 14,
        ST_ENT_NUM    = 21'd1 << 15,
        ST_ENT_DIV    = 21'd1 << 16,
        ST_ENT_WAIT   = 21'd1 << 17,
        ST_ZERO       = 21'd1 << 18,
        ST_SINE       = 21'd1 << 19,
        ST_DONE       = 21'd1 << 20
    } state_t;

    localparam logic [IDX_W-1:0] TABLE_END = IDX_W'(TABLE_SIZE);
    localparam int PROD_W = FREQ_W + HALF_W;
    localparam int FULL_W = FREQ_W + INC_W;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic                     rise_mode_reg, rise_mode_next;
    logic                     m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]         fall_end_reg, fall_end_next;
    logic [IDX_W-1:0]         zero_end_reg, zero_end_next;
    logic [FREQ_W-1:0]        freq_reg, freq_next;
    logic [AMP_W-1:0]         amp_reg, amp_next;
    logic [PROD_W-1:0]        prod_lo_reg, prod_lo_next;
    logic [PROD_W-1:0]        prod_hi_reg, prod_hi_next;
    logic [SAMPLE_BITS-1:0]   lo_val_reg, lo_val_next;
    logic [T_W-1:0]           t_reg, t_next;
    logic [SHRINK_W-1:0]      p_reg, p_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [SQ_W-1:0]          m1_reg, m1_next;
    logic [DEN_W-1:0]         num_reg, num_next;
    out_t                     res_reg, res_next;
    out_t                     m_data_reg, m_data_next;

    // Table bounds and per-entry operands.
    logic [IDX_W-1:0]         d1;
    logic [IDX_W-1:0]         d2;
    logic [IDX_W-1:0]         d2_clip;
    logic [IDX_W-1:0]         idx_inc;
    logic [IDX_W-1:0]         seg_end;
    logic [IDX_W-1:0]         x_val;
    logic [IDX_W-1:0]         len;
    logic [FAC_W-1:0]         rise_fac;
    logic [FULL_W-1:0]        full_prod;
    logic [PHASE_W-1:0]       step;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [2*SAMPLE_BITS+1:0] interp_prod;
    logic [SHRINK_W-PHASE_FRAC-1:0] shrink_q;
    logic [PHASE_FRAC-1:0]    shrink_rem;
    logic [SHRINK_W-PHASE_FRAC-1:0] shrink;
    logic [IDX_W-1:0]         span;
    logic [QIDX_W-1:0]        q_idx;
    logic [SAMPLE_BITS-1:0]   sine_mag;
    logic [QUOT_W-1:0]        quot_clip;

    // Table port and divider request.
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [SAMPLE_BITS-1:0]   ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [SAMPLE_BITS-1:0]   ram_rdata;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    gwo_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(TABLE_SIZE)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gwo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Clamp the configured bounds into the table.
    always_comb begin
        d1      = (cfg.rise_end > TABLE_END) ? TABLE_END : cfg.rise_end;
        d2_clip = (cfg.fall_end_max > TABLE_END) ? TABLE_END : cfg.fall_end_max;
        d2      = (d2_clip < d1) ? d1 : d2_clip;
    end

    // Operands shared by the state machine.
    always_comb begin
        idx_inc     = idx_reg + 1'b1;
        seg_end     = rise_mode_reg ? d1 : fall_end_reg;
        x_val       = rise_mode_reg ? idx_reg : idx_reg - d1;
        len         = fall_end_reg - d1;
        rise_fac    = ({2'b00, d1} << 1) + {2'b00, d1} - {1'b0, idx_reg, 1'b0};
        full_prod   = FULL_W'(prod_lo_reg) + (FULL_W'(prod_hi_reg) << HALF_W);
        step        = full_prod[STEP_SHIFT +: PHASE_W];
        diff        = $signed({ram_rdata[SAMPLE_BITS-1], ram_rdata})
                    - $signed({lo_val_reg[SAMPLE_BITS-1], lo_val_reg});
        interp_prod = diff * $signed({1'b0, phase_reg[PHASE_FRAC-1:0]});
        shrink_q    = p_reg[SHRINK_W-1:PHASE_FRAC];
        shrink_rem  = p_reg[PHASE_FRAC-1:0];
        shrink      = shrink_q;
        if ((shrink_rem > (PHASE_FRAC'(1) << (PHASE_FRAC - 1)))
            || ((shrink_rem == (PHASE_FRAC'(1) << (PHASE_FRAC - 1))) && shrink_q[0])) begin
            shrink = shrink_q + 1'b1;
        end
        span        = d2 - d1;
        // Quadrant symmetry folds the table index onto a quarter period.
        if (idx_reg[ADDR_W-2]) begin
            q_idx = QIDX_W'(QUARTER) - {1'b0, idx_reg[QIDX_W-2:0]};
        end else begin
            q_idx = {1'b0, idx_reg[QIDX_W-2:0]};
        end
        sine_mag    = SINE_ROM[q_idx];
        quot_clip   = (div_rsp.quot > SAMPLE_MAX) ? SAMPLE_MAX : div_rsp.quot;
    end

    // Sequencer for table clearing and sample, update, rebuild and no-op commands.
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        rise_mode_next = rise_mode_reg;
        fall_end_next  = fall_end_reg;
        zero_end_next  = zero_end_reg;
        freq_next      = freq_reg;
        amp_next       = amp_reg;
        prod_lo_next   = prod_lo_reg;
        prod_hi_next   = prod_hi_reg;
        lo_val_next    = lo_val_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        sq_next        = sq_reg;
        den_next       = den_reg;
        m1_next        = m1_reg;
        num_next       = num_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[ADDR_W-1:0];
        ram_wdata      = '0;
        ram_raddr      = phase_reg[PHASE_W-1:PHASE_FRAC];
        div_req.start  = 1'b0;
        div_req.num    = NUM_W'({num_reg, {(SAMPLE_BITS - 1){1'b0}}}) + NUM_W'(den_reg >> 1);
        div_req.den    = den_reg;
        stat.pop       = 1'b0;

        // The result register empties when the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we   = 1'b1;
                idx_next = idx_inc;
                if (idx_reg == TABLE_END - 1'b1) begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
            end
            ST_IDLE: begin
                if (head.valid) begin
                    stat.pop  = 1'b1;
                    freq_next = head.job.frequency;
                    amp_next  = head.job.amplitude;
                    res_next  = '0;
                    case (head.job.cmd)
                        CMD_SAMPLE: begin
                            state_next = ST_MUL_LO;
                        end
                        CMD_UPDATE: begin
                            state_next = ST_UPD_MUL;
                        end
                        CMD_REBUILD_PULSE: begin
                            phase_next     = '0;
                            idx_next       = '0;
                            rise_mode_next = 1'b1;
                            fall_end_next  = d2;
                            zero_end_next  = TABLE_END;
                            state_next     = ST_RISE_SQ;
                        end
                        CMD_REBUILD_SINE: begin
                            phase_next = '0;
                            idx_next   = '0;
                            state_next = ST_SINE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            // Phase step is the 56-bit product taken in two halves.
            ST_MUL_LO: begin
                prod_lo_next = freq_reg * cfg.increment_per_hz[HALF_W-1:0];
                state_next   = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                prod_hi_next = freq_reg * cfg.increment_per_hz[INC_W-1:HALF_W];
                state_next   = ST_PHASE;
            end
            ST_PHASE: begin
                phase_next = phase_reg + step;
                state_next = ST_RD_LO;
            end
            ST_RD_LO: begin
                state_next = ST_RD_HI;
            end
            ST_RD_HI: begin
                ram_raddr   = phase_reg[PHASE_W-1:PHASE_FRAC] + 1'b1;
                lo_val_next = ram_rdata;
                state_next  = ST_INTERP;
            end
            ST_INTERP: begin
                t_next     = T_W'(interp_prod + (2 * SAMPLE_BITS + 2)'(1 << (PHASE_FRAC - 1)));
                state_next = ST_SUM;
            end
            ST_SUM: begin
                res_next.sample    = lo_val_reg + t_reg[PHASE_FRAC +: SAMPLE_BITS];
                res_next.is_sample = 1'b1;
                state_next         = ST_DONE;
            end
            // Update: shorten the fall by the rounded amplitude share.
            ST_UPD_MUL: begin
                p_next     = amp_reg * cfg.fall_shrink_max;
                state_next = ST_UPD_END;
            end
            ST_UPD_END: begin
                if (shrink > (SHRINK_W - PHASE_FRAC)'(span)) begin
                    fall_end_next = d1;
                end else begin
                    fall_end_next = d2 - IDX_W'(shrink);
                end
                zero_end_next  = d2;
                rise_mode_next = 1'b0;
                state_next     = ST_FALL_SQ;
            end
            ST_RISE_SQ: begin
                if (d1 == '0) begin
                    state_next = ST_FALL_SQ;
                end else begin
                    sq_next    = SQ_W'(d1 * d1);
                    state_next = ST_RISE_CUBE;
                end
            end
            ST_RISE_CUBE: begin
                den_next   = DEN_W'(sq_reg * d1);
                state_next = ST_ENT_SQ;
            end
            ST_FALL_SQ: begin
                rise_mode_next = 1'b0;
                idx_next       = d1;
                if (len == '0) begin
                    state_next = ST_ZERO;
                end else begin
                    den_next   = DEN_W'(len * len);
                    state_next = ST_ENT_SQ;
                end
            end
            // One entry of the rise or the fall per divider run.
            ST_ENT_SQ: begin
                m1_next    = SQ_W'(x_val * x_val);
                state_next = ST_ENT_NUM;
            end
            ST_ENT_NUM: begin
                if (rise_mode_reg) begin
                    num_next = DEN_W'(m1_reg * rise_fac);
                end else begin
                    num_next = DEN_W'(den_reg[SQ_W-1:0] - m1_reg);
                end
                state_next = ST_ENT_DIV;
            end
            ST_ENT_DIV: begin
                div_req.start = 1'b1;
                state_next    = ST_ENT_WAIT;
            end
            ST_ENT_WAIT: begin
                if (div_rsp.done) begin
                    ram_we    = 1'b1;
                    ram_wdata = quot_clip;
                    idx_next  = idx_inc;
                    if (idx_inc == seg_end) begin
                        state_next = rise_mode_reg ? ST_FALL_SQ : ST_ZERO;
                    end else begin
                        state_next = ST_ENT_SQ;
                    end
                end
            end
            ST_ZERO: begin
                if (idx_reg == zero_end_reg) begin
                    state_next = ST_DONE;
                end else begin
                    ram_we   = 1'b1;
                    idx_next = idx_inc;
                end
            end
            ST_SINE: begin
                ram_we    = 1'b1;
                ram_wdata = idx_reg[ADDR_W-1] ? -sine_mag : sine_mag;
                idx_next  = idx_inc;
                if (idx_reg == TABLE_END - 1'b1) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign stat.hold = (state_reg == ST_CLEAR);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            phase_reg     <= '0;
            rise_mode_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            rise_mode_reg <= rise_mode_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        fall_end_reg <= fall_end_next;
        zero_end_reg <= zero_end_next;
        freq_reg     <= freq_next;
        amp_reg      <= amp_next;
        prod_lo_reg  <= prod_lo_next;
        prod_hi_reg  <= prod_hi_next;
        lo_val_reg   <= lo_val_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        sq_reg       <= sq_next;
        den_reg      <= den_next;
        m1_reg       <= m1_next;
        num_reg      <= num_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ bench/gwo_checker.sv @@
`timescale 1ns / 1ps

module gwo_checker import gwo_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_t                   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_t                  m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    outstanding
);

    // Shadow copy of the oscillator state and its registers.
    int                  wave_mem [TABLE_SIZE];
    logic [PHASE_W-1:0]  osc_phase;
    logic                shadow_mode;
    int unsigned         shadow_rise;
    int unsigned         shadow_fall;
    int unsigned         shadow_shrink;
    logic [INC_W-1:0]    shadow_step_hz;

    // Results still owed by the block, oldest first.
    out_t due_outputs [$];

    function automatic int saturate_top(longint unsigned v);
        return (v > FULL_SCALE - 1) ? int'(FULL_SCALE - 1) : int'(v);
    endfunction

    function automatic int unsigned rise_limit();
        return (shadow_rise > TABLE_SIZE) ? TABLE_SIZE : shadow_rise;
    endfunction

    function automatic int unsigned fall_limit(int unsigned d1);
        int unsigned d2;
        d2 = (shadow_fall > TABLE_SIZE) ? TABLE_SIZE : shadow_fall;
        return (d2 < d1) ? d1 : d2;
    endfunction

    // Falling part 1 - x^2 from start up to stop.
    function automatic void write_decay(int unsigned start, int unsigned stop);
        longint unsigned span;
        longint unsigned span_sq;
        longint unsigned num;
        span    = stop - start;
        span_sq = span * span;
        for (int unsigned j = 0; j < span; j++) begin
            num = FULL_SCALE * (span_sq - longint'(j) * j);
            wave_mem[start + j] = saturate_top((num + span_sq / 2) / span_sq);
        end
    endfunction

    // One sine entry from a Q32 angle fraction and a Q30 series.
    function automatic int sine_point(int unsigned i);
        longint unsigned frac32;
        longint unsigned r;
        longint unsigned x;
        longint unsigned term;
        longint unsigned acc;
        int unsigned     quad;
        int              mag;
        frac32 = (longint'(i) << 32) / TABLE_SIZE;
        quad   = int'((frac32 >> 30) & 3);
        r      = frac32 & 64'h3FFF_FFFF;
        if (quad[0]) begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * TWO_PI_Q30) >> 32;
        acc  = x;
        term = x;
        for (int k = 1; k <= 6; k++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = (acc >= term) ? acc - term : 0;
            end else begin
                acc = acc + term;
            end
        end
        mag = saturate_top((acc * FULL_SCALE + (64'd1 << 29)) >> 30);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic void rebuild_wave();
        int unsigned     d1;
        int unsigned     d2;
        longint unsigned den;
        longint unsigned num;
        osc_phase = '0;
        if (shadow_mode) begin
            for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
                wave_mem[i] = sine_point(i);
            end
        end else begin
            d1  = rise_limit();
            d2  = fall_limit(d1);
            den = longint'(d1) * d1 * d1;
            for (int unsigned i = 0; i < d1; i++) begin
                num = FULL_SCALE * i * i * (3 * longint'(d1) - 2 * longint'(i));
                wave_mem[i] = saturate_top((num + den / 2) / den);
            end
            write_decay(d1, d2);
            for (int unsigned i = d2; i < TABLE_SIZE; i++) begin
                wave_mem[i] = 0;
            end
        end
    endfunction

    // Shorten the fall by amplitude times the shrink, rounded half to even.
    function automatic void shorten_fall(int unsigned amp);
        int unsigned     d1;
        int unsigned     d2;
        int unsigned     nd2;
        longint unsigned prod;
        longint unsigned cut;
        longint unsigned rem;
        if (shadow_mode) begin
            return;
        end
        if (amp > 65536) begin
            amp = 65536;
        end
        d1   = rise_limit();
        d2   = fall_limit(d1);
        prod = longint'(amp) * shadow_shrink;
        cut  = prod >> 16;
        rem  = prod & 64'hFFFF;
        if (rem > 32768 || (rem == 32768 && cut[0])) begin
            cut++;
        end
        nd2 = (cut > d2 - d1) ? d1 : d2 - int'(cut);
        write_decay(d1, nd2);
        for (int unsigned i = nd2; i < d2; i++) begin
            wave_mem[i] = 0;
        end
    endfunction

    // Samples advance the phase and interpolate two neighbouring entries.
    function automatic out_t osc_apply(in_t req);
        out_t                   res;
        logic [63:0]            step;
        logic [ADDR_W-1:0]      lo;
        logic [ADDR_W-1:0]      hi;
        longint                 t;
        res = '0;
        case (req.opcode)
            OP_SAMPLE: begin
                step      = (64'(req.frequency) * 64'(shadow_step_hz)) >> STEP_SHIFT;
                osc_phase = osc_phase + step[PHASE_W-1:0];
                lo        = osc_phase[PHASE_W-1:PHASE_FRAC];
                hi        = lo + 1'b1;
                t = longint'(wave_mem[hi] - wave_mem[lo]) *
                    longint'(osc_phase[PHASE_FRAC-1:0]) + 32768;
                res.sample    = SAMPLE_BITS'(longint'(wave_mem[lo]) + (t >>> PHASE_FRAC));
                res.is_sample = 1'b1;
            end
            OP_UPDATE:  shorten_fall(int'(req.amplitude));
            OP_REBUILD: rebuild_wave();
            default: ;
        endcase
        return res;
    endfunction

    // Register writes, request intake and result comparison.
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            foreach (wave_mem[i]) wave_mem[i] = 0;
            osc_phase      = '0;
            shadow_mode    = 1'b0;
            shadow_rise    = 205;
            shadow_fall    = 369;
            shadow_shrink  = 82;
            shadow_step_hz = 32'd49864474;
            due_outputs.delete();
            mismatches  <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_WAVEFORM_MODE:    shadow_mode    = cfg_wdata[0];
                    REG_RISE_END:         shadow_rise    = cfg_wdata[IDX_W-1:0];
                    REG_FALL_END_MAX:     shadow_fall    = cfg_wdata[IDX_W-1:0];
                    REG_FALL_SHRINK_MAX:  shadow_shrink  = cfg_wdata[IDX_W-1:0];
                    REG_INCREMENT_PER_HZ: shadow_step_hz = cfg_wdata[INC_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_outputs.size() == 0) begin
                    $error("result with no request outstanding: sample %0d, is_sample %0b",
                           m_data.sample, m_data.is_sample);
                    mismatches <= mismatches + 1;
                end else begin
                    want = due_outputs.pop_front();
                    if (m_data.sample !== want.sample || m_data.is_sample !== want.is_sample) begin
                        mismatches <= mismatches + 1;
                    end
                    if (m_data.sample !== want.sample) begin
                        $error("sample: expected %0d, got %0d", want.sample, m_data.sample);
                    end
                    if (m_data.is_sample !== want.is_sample) begin
                        $error("is_sample: expected %0b, got %0b",
                               want.is_sample, m_data.is_sample);
                    end
                end
            end
            if (s_valid && s_ready) begin
                due_outputs.push_back(osc_apply(s_data));
            end
        end
        outstanding <= due_outputs.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import gwo_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_IDLE = 2'd3;
    localparam int CYCLE_LIMIT = 50000000;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 112;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WAVEFORM_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    bit quiet_mode = 1'b0;
    bit park_reader = 1'b0;
    int sent_samples = 0;
    int sent_updates = 0;
    int sent_rebuilds = 0;
    int settings_used = 0;

    glottal_wavetable_oscillator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    gwo_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (park_reader) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                park_reader = 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until the block takes it.
    task automatic offer(input logic [OPCODE_W-1:0] op, input logic [FREQ_W-1:0] freq,
                         input logic [AMP_W-1:0] amp);
        s_valid          <= 1'b1;
        s_data.opcode    <= op;
        s_data.frequency <= freq;
        s_data.amplitude <= amp;
        do @(posedge aclk); while (!s_ready);
        case (op)
            OP_SAMPLE:  sent_samples++;
            OP_UPDATE:  sent_updates++;
            OP_REBUILD: sent_rebuilds++;
            default: ;
        endcase
        if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Stop sending until every owed result has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic load_settings(input logic mode, input int unsigned rise,
                                 input int unsigned fall, input int unsigned shrink,
                                 input logic [31:0] step_hz);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_WAVEFORM_MODE;    cfg_wdata <= 32'(mode);   @(posedge aclk);
        cfg_index <= REG_RISE_END;         cfg_wdata <= rise;        @(posedge aclk);
        cfg_index <= REG_FALL_END_MAX;     cfg_wdata <= fall;        @(posedge aclk);
        cfg_index <= REG_FALL_SHRINK_MAX;  cfg_wdata <= shrink;      @(posedge aclk);
        cfg_index <= REG_INCREMENT_PER_HZ; cfg_wdata <= step_hz;     @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Mostly samples; table work is rarer where the table is large.
    task automatic random_request(input int heavy_pct);
        int pick;
        logic [OPCODE_W-1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < heavy_pct / 2) begin
            op = OP_REBUILD;
        end else if (pick < heavy_pct) begin
            op = OP_UPDATE;
        end else if (pick < heavy_pct + 4) begin
            op = OP_IDLE;
        end else begin
            op = OP_SAMPLE;
        end
        offer(op, FREQ_W'($urandom), AMP_W'($urandom_range(0, 131071)));
    endtask

    initial begin
        logic        mode;
        int unsigned rise;
        int unsigned fall;
        int unsigned shrink;
        logic [31:0] step_hz;
        int          heavy_pct;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests on the reset settings.
        offer(OP_SAMPLE, 24'h0, '0);
        offer(OP_SAMPLE, 24'hFFFFFF, '0);
        offer(OP_REBUILD, '0, '0);
        offer(OP_SAMPLE, 24'h0, '0);
        offer(OP_SAMPLE, 24'd25600, '0);
        offer(OP_SAMPLE, 24'hFFFFFF, '0);
        offer(OP_SAMPLE, 24'h800000, 17'h1FFFF);
        offer(OP_UPDATE, '0, 17'd0);
        offer(OP_SAMPLE, 24'h123456, '0);
        offer(OP_UPDATE, '0, AMP_ONE);
        offer(OP_UPDATE, '0, 17'h1FFFF);
        offer(OP_UPDATE, '0, 17'd32768);
        offer(OP_SAMPLE, 24'h00FF00, '0);
        offer(OP_IDLE, 24'hFFFFFF, 17'h1FFFF);
        offer(OP_REBUILD, '0, '0);
        offer(OP_SAMPLE, 24'd1, '0);
        drain();

        // Phases of random traffic, each with its own register setting.
        for (int p = 0; p < PHASES; p++) begin
            mode      = ($urandom_range(0, 3) == 0);
            rise      = $urandom_range(0, 64);
            fall      = rise + $urandom_range(0, 64);
            shrink    = $urandom_range(0, 1023);
            step_hz   = $urandom;
            heavy_pct = 20;
            case (p)
                0: mode = 1'b1;
                1: begin
                    mode = 1'b0; rise = 1023; fall = 1023; shrink = 1023;
                    step_hz = 32'hFFFFFFFF; heavy_pct = 2;
                end
                2: begin
                    mode = 1'b0; rise = 0; fall = 0; shrink = 0; step_hz = 32'h0;
                end
                3: begin
                    mode = 1'b0; rise = 40; fall = 10;
                end
                4: begin
                    mode = 1'b0; rise = 511; fall = 512; shrink = 512; heavy_pct = 2;
                end
                default: ;
            endcase
            quiet_mode = (p >= PHASES - 2);
            load_settings(mode, rise, fall, shrink, step_hz);
            if ($urandom_range(0, 4) != 0) begin
                offer(OP_REBUILD, FREQ_W'($urandom), '0);
            end
            if (p == 5) begin
                park_reader = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_request(heavy_pct);
            end
            drain();
        end

        repeat (50) @(posedge aclk);
        $display("Covered %0d sample, %0d update and %0d rebuild requests",
                 sent_samples, sent_updates, sent_rebuilds);
        $display("over %0d register settings, pulse and sine tables and clamped bounds.",
                 settings_used);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
